FILE: sv/gcfr_pkg.sv
package gcfr_pkg;

	localparam int VAL_W  = 32;
	localparam int FRAC_W = 16;
	localparam int NRM_W  = 16;
	localparam int NRM_FB = 14;
	localparam int REST_W = 18;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SPACING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_TIMESTEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION   = 2'd2;

	localparam logic [31:0]       CELL_SPACING_RST = 32'd3277;
	localparam logic [31:0]       INV_TIMESTEP_RST = 32'd655360000;
	localparam logic [REST_W-1:0] RESTITUTION_RST  = '0;

	typedef struct packed {
		logic               node_active;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] nearest_distance;
		logic signed [31:0] previous_distance;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [31:0]        surface_friction;
	} node_t;

	typedef struct packed {
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic               collided;
		logic               sliding;
		logic               saturated;
	} result_t;

	// classified node handed from the front end to the arithmetic pipeline
	typedef struct packed {
		logic                  coll;
		logic [2:0][VAL_W-1:0] vel;
		logic [2:0][NRM_W-1:0] nrm;
		logic [31:0]           fric;
		logic [31:0]           depth;
	} work_t;

endpackage

FILE: sv/grid_collision_friction_response_unit.sv
// Grid-node collision response with Coulomb friction. One node enters per clock and one result
// leaves per clock when pop keeps up. A node passes the front-end register that classifies it,
// the classified-node queue and a 79-stage arithmetic pipeline whose length is set by the
// 32-stage square root of the tangential speed and the three 32-stage dividers that scale the
// friction per axis. When the result queue fills, the whole arithmetic pipeline holds; the
// front end and its queue keep taking nodes until that queue is full too. No clearing pass
// follows reset.
module grid_collision_friction_response_unit #(
	parameter int QUEUE_DEPTH  = 4,
	parameter int RESULT_DEPTH = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  gcfr_pkg::node_t                      node,
	output logic                                 full,
	output logic                                 empty,
	input  logic                                 pop,
	output gcfr_pkg::result_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gcfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                          cfg_data
);

	logic [31:0]                 cell_spacing_q;
	logic [31:0]                 inv_ts_q;
	logic [gcfr_pkg::REST_W-1:0] restitution_q;

	gcfr_pkg::work_t   fr_data, mq_dout;
	gcfr_pkg::result_t bk_result;
	logic [$bits(gcfr_pkg::result_t)-1:0] oq_dout;
	logic fr_push, mq_full, mq_empty, bk_take, oq_full, oq_push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_spacing_q <= gcfr_pkg::CELL_SPACING_RST;
			inv_ts_q       <= gcfr_pkg::INV_TIMESTEP_RST;
			restitution_q  <= gcfr_pkg::RESTITUTION_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gcfr_pkg::CFG_CELL_SPACING: begin
					cell_spacing_q <= cfg_data;
				end
				gcfr_pkg::CFG_INV_TIMESTEP: begin
					inv_ts_q <= cfg_data;
				end
				gcfr_pkg::CFG_RESTITUTION: begin
					restitution_q <= cfg_data[gcfr_pkg::REST_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	gcfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.node         (node),
		.full         (full),
		.cell_spacing (cell_spacing_q),
		.mq_full      (mq_full),
		.mq_push      (fr_push),
		.mq_data      (fr_data)
	);

	gcfr_queue #(
		.WIDTH ($bits(gcfr_pkg::work_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.din    (fr_data),
		.full   (mq_full),
		.pop    (bk_take),
		.dout   (mq_dout),
		.empty  (mq_empty)
	);

	gcfr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.work             (mq_dout),
		.avail            (!mq_empty),
		.take             (bk_take),
		.inverse_timestep (inv_ts_q),
		.restitution      (restitution_q),
		.oq_full          (oq_full),
		.oq_push          (oq_push),
		.result           (bk_result)
	);

	gcfr_queue #(
		.WIDTH ($bits(gcfr_pkg::result_t)),
		.DEPTH (RESULT_DEPTH)
	) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.din    (bk_result),
		.full   (oq_full),
		.pop    (pop),
		.dout   (oq_dout),
		.empty  (empty)
	);

	assign result = oq_dout;

	// a node that missed the obstacle carries no friction or clip flags
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.collided |-> !result.sliding && !result.saturated)
		else $error("flags set on a node without collision");

	// the front end only blocks input when the classified-node queue is backed up
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mq_full)
		else $error("input blocked while the node queue has room");

	// the pipeline moves only when the result queue can take what leaves it
	assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> !oq_full)
		else $error("result pushed into a full queue");

endmodule

FILE: sv/gcfr_queue.sv
module gcfr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             wr, rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

FILE: sv/gcfr_front.sv
module gcfr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gcfr_pkg::node_t     node,
	output logic                full,
	input  logic [31:0]         cell_spacing,
	input  logic                mq_full,
	output logic                mq_push,
	output gcfr_pkg::work_t     mq_data
);

	gcfr_pkg::node_t    node_s1;
	logic               vld_q;
	logic               rdy;
	logic signed [31:0] d, p;
	logic signed [33:0] dcomp;
	logic [31:0]        absd;

	assign rdy     = !vld_q || !mq_full;
	assign full    = !rdy;
	assign mq_push = vld_q && !mq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rdy) begin
			vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && rdy) begin
			node_s1 <= node;
		end
	end

	// depth measured against the earlier distance when that one was already inside
	always_comb begin
		d     = node_s1.nearest_distance;
		p     = node_s1.previous_distance;
		dcomp = 34'(d) - (p[31] ? 34'(p) : 34'sd0);
		absd  = d[31] ? (~d + 32'd1) : d;

		mq_data.coll   = node_s1.node_active && (absd <= cell_spacing) && dcomp[33];
		mq_data.vel[0] = node_s1.vel_x;
		mq_data.vel[1] = node_s1.vel_y;
		mq_data.vel[2] = node_s1.vel_z;
		mq_data.nrm[0] = node_s1.normal_x;
		mq_data.nrm[1] = node_s1.normal_y;
		mq_data.nrm[2] = node_s1.normal_z;
		mq_data.fric   = node_s1.surface_friction;
		mq_data.depth  = 32'(-dcomp);
	end

endmodule

FILE: sv/gcfr_back.sv
module gcfr_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gcfr_pkg::work_t                     work,
	input  logic                                avail,
	output logic                                take,
	input  logic [31:0]                         inverse_timestep,
	input  logic [gcfr_pkg::REST_W-1:0]         restitution,
	input  logic                                oq_full,
	output logic                                oq_push,
	output gcfr_pkg::result_t                   result
);

	localparam int ROOT_BITS = 32;
	localparam int QUO_BITS  = 32;
	localparam int S_M1   = 1;
	localparam int S_DV   = 2;
	localparam int S_M2   = 3;
	localparam int S_PUSH = 4;
	localparam int S_PN   = 5;
	localparam int S_V1   = 6;
	localparam int S_VNP  = 7;
	localparam int S_VN   = 8;
	localparam int S_VNN  = 9;
	localparam int S_VT   = 10;
	localparam int S_SQ   = 11;
	localparam int S_SS   = 12;
	localparam int S_RT0  = 13;
	localparam int S_SLD  = S_RT0 + ROOT_BITS;
	localparam int S_NUM  = S_SLD + 1;
	localparam int S_DQ0  = S_NUM + 1;
	localparam int S_OUT  = S_DQ0 + QUO_BITS;
	localparam int NST    = S_OUT;

	typedef struct packed {
		logic             coll;
		logic             sat;
		logic             slide;
		logic [2:0][31:0] vin;
		logic [2:0][31:0] v1;
		logic [2:0][31:0] vt;
		logic [2:0][31:0] q;
		logic [2:0][31:0] vout;
		logic [2:0][15:0] nrm;
		logic [31:0]      fric;
		logic [31:0]      depth;
		logic [31:0]      dv;
		logic [31:0]      nvt;
		logic [63:0]      m1;
		logic [63:0]      mf;
		logic [63:0]      ss;
		logic [50:0]      m2;
		logic [35:0]      push;
		logic [47:0]      fdv;
		logic [2:0][52:0] pn;
		logic [2:0][47:0] vnp;
		logic [35:0]      vn;
		logic [2:0][51:0] vnn;
		logic [2:0][63:0] sq;
		logic [2:0][63:0] num;
		logic [33:0]      srem;
		logic [2:0][31:0] drem;
	} ctx_t;

	// {clipped flag, value} for the signed 32-bit range
	function automatic logic [32:0] clip32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return {1'b1, 32'h7fff_ffff};
		end else if (x < -64'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, x[31:0]};
	endfunction

	// round to nearest, ties up, dropping the normal fraction
	function automatic logic signed [63:0] rsh_nrm(input logic signed [63:0] x);
		return (x + (64'sd1 <<< (gcfr_pkg::NRM_FB - 1))) >>> gcfr_pkg::NRM_FB;
	endfunction

	ctx_t       entry;
	ctx_t       prv    [1:NST];
	ctx_t       nxt    [1:NST];
	ctx_t       pipe_s [1:NST];
	logic [NST:1] vld_q;
	logic       adv;

	assign adv     = !oq_full;
	assign take    = adv && avail;
	assign oq_push = adv && vld_q[NST];

	always_comb begin
		entry       = '0;
		entry.coll  = work.coll;
		entry.vin   = work.vel;
		entry.nrm   = work.nrm;
		entry.fric  = work.fric;
		entry.depth = work.depth;
	end

	assign prv[1] = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-1:1], avail};
		end
	end

	generate
		for (genvar k = 1; k <= NST; k++) begin : g_st
			if (k > 1) begin : g_link
				assign prv[k] = pipe_s[k-1];
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					pipe_s[k] <= nxt[k];
				end
			end

			if (k == S_M1) begin : g_m1
				always_comb begin
					nxt[k]    = prv[k];
					nxt[k].m1 = 64'(prv[k].depth) * 64'(inverse_timestep);
				end
			end else if (k == S_DV) begin : g_dv
				logic [63:0] t;
				always_comb begin
					nxt[k] = prv[k];
					t      = prv[k].m1 + 64'd32768;
					if (|t[63:48]) begin
						nxt[k].dv  = '1;
						nxt[k].sat = 1'b1;
					end else begin
						nxt[k].dv = t[47:16];
					end
				end
			end else if (k == S_M2) begin : g_m2
				always_comb begin
					nxt[k]    = prv[k];
					nxt[k].m2 = 51'(prv[k].dv) * (51'(32'h0001_0000) + 51'(restitution));
					nxt[k].mf = 64'(prv[k].dv) * 64'(prv[k].fric);
				end
			end else if (k == S_PUSH) begin : g_push
				logic [51:0] t2;
				logic [64:0] t3;
				always_comb begin
					nxt[k]      = prv[k];
					t2          = 52'(prv[k].m2) + 52'd32768;
					t3          = 65'(prv[k].mf) + 65'd32768;
					nxt[k].push = t2[51:16];
					nxt[k].fdv  = t3[63:16];
				end
			end else if (k == S_PN) begin : g_pn
				always_comb begin
					nxt[k] = prv[k];
					for (int i = 0; i < 3; i++) begin
						nxt[k].pn[i] = 53'($signed({1'b0, prv[k].push}))
							* 53'($signed(prv[k].nrm[i]));
					end
				end
			end else if (k == S_V1) begin : g_v1
				logic [2:0][32:0] c;
				always_comb begin
					nxt[k] = prv[k];
					for (int i = 0; i < 3; i++) begin
						c[i] = clip32(64'($signed(prv[k].vin[i]))
							+ rsh_nrm(64'($signed(prv[k].pn[i]))));
						nxt[k].v1[i] = c[i][31:0];
					end
					nxt[k].sat = prv[k].sat | c[0][32] | c[1][32] | c[2][32];
				end
			end else if (k == S_VNP) begin : g_vnp
				always_comb begin
					nxt[k] = prv[k];
					for (int i = 0; i < 3; i++) begin
						nxt[k].vnp[i] = 48'($signed(prv[k].v1[i])) * 48'($signed(prv[k].nrm[i]));
					end
				end
			end else if (k == S_VN) begin : g_vn
				logic signed [63:0] s;
				logic signed [63:0] r;
				always_comb begin
					nxt[k]    = prv[k];
					s         = 64'($signed(prv[k].vnp[0])) + 64'($signed(prv[k].vnp[1]))
						+ 64'($signed(prv[k].vnp[2]));
					r         = rsh_nrm(s);
					nxt[k].vn = r[35:0];
				end
			end else if (k == S_VNN) begin : g_vnn
				always_comb begin
					nxt[k] = prv[k];
					for (int i = 0; i < 3; i++) begin
						nxt[k].vnn[i] = 52'($signed(prv[k].vn)) * 52'($signed(prv[k].nrm[i]));
					end
				end
			end else if (k == S_VT) begin : g_vt
				logic [2:0][32:0] c;
				always_comb begin
					nxt[k] = prv[k];
					for (int i = 0; i < 3; i++) begin
						c[i] = clip32(64'($signed(prv[k].v1[i]))
							- rsh_nrm(64'($signed(prv[k].vnn[i]))));
						nxt[k].vt[i] = c[i][31:0];
					end
					nxt[k].sat = prv[k].sat | c[0][32] | c[1][32] | c[2][32];
				end
			end else if (k == S_SQ) begin : g_sq
				always_comb begin
					nxt[k] = prv[k];
					for (int i = 0; i < 3; i++) begin
						nxt[k].sq[i] = 64'($signed(prv[k].vt[i])) * 64'($signed(prv[k].vt[i]));
					end
				end
			end else if (k == S_SS) begin : g_ss
				// sum of squares wraps at 64 bits
				always_comb begin
					nxt[k]      = prv[k];
					nxt[k].ss   = prv[k].sq[0] + prv[k].sq[1] + prv[k].sq[2];
					nxt[k].srem = '0;
					nxt[k].nvt  = '0;
				end
			end else if (k < S_SLD) begin : g_root
				// one root bit per stage, msb first
				localparam int B = S_RT0 + ROOT_BITS - 1 - k;
				logic [35:0] sh;
				logic [35:0] tr;
				always_comb begin
					nxt[k] = prv[k];
					sh     = {prv[k].srem, prv[k].ss[2*B+1 -: 2]};
					tr     = {2'b00, prv[k].nvt, 2'b01};
					if (sh >= tr) begin
						nxt[k].srem = 34'(sh - tr);
						nxt[k].nvt  = {prv[k].nvt[30:0], 1'b1};
					end else begin
						nxt[k].srem = sh[33:0];
						nxt[k].nvt  = {prv[k].nvt[30:0], 1'b0};
					end
				end
			end else if (k == S_SLD) begin : g_sld
				logic [2:0][31:0] mag;
				always_comb begin
					nxt[k]       = prv[k];
					nxt[k].slide = {16'b0, prv[k].nvt} > prv[k].fdv;
					for (int i = 0; i < 3; i++) begin
						mag[i] = prv[k].vt[i][31] ? (~prv[k].vt[i] + 32'd1) : prv[k].vt[i];
						// fdv is below the root whenever the node slides
						nxt[k].num[i] = 64'(mag[i]) * 64'(prv[k].fdv[31:0]);
					end
				end
			end else if (k == S_NUM) begin : g_num
				logic [2:0][63:0] t;
				always_comb begin
					nxt[k] = prv[k];
					for (int i = 0; i < 3; i++) begin
						t[i]           = prv[k].num[i] + 64'(prv[k].nvt[31:1]);
						nxt[k].num[i]  = t[i];
						nxt[k].drem[i] = t[i][63:32];
						nxt[k].q[i]    = '0;
					end
				end
			end else if (k < S_OUT) begin : g_div
				// one quotient bit per stage in each of the three lanes
				localparam int B = S_DQ0 + QUO_BITS - 1 - k;
				logic [2:0][32:0] sh;
				always_comb begin
					nxt[k] = prv[k];
					for (int i = 0; i < 3; i++) begin
						sh[i] = {prv[k].drem[i], prv[k].num[i][B]};
						if (sh[i] >= {1'b0, prv[k].nvt}) begin
							nxt[k].drem[i] = 32'(sh[i] - {1'b0, prv[k].nvt});
							nxt[k].q[i]    = {prv[k].q[i][30:0], 1'b1};
						end else begin
							nxt[k].drem[i] = sh[i][31:0];
							nxt[k].q[i]    = {prv[k].q[i][30:0], 1'b0};
						end
					end
				end
			end else begin : g_out
				logic signed [63:0] x [3];
				logic [2:0][32:0]   c;
				always_comb begin
					nxt[k] = prv[k];
					for (int i = 0; i < 3; i++) begin
						if (!prv[k].slide) begin
							x[i] = 64'($signed(prv[k].v1[i])) - 64'($signed(prv[k].vt[i]));
						end else if (prv[k].vt[i][31]) begin
							x[i] = 64'($signed(prv[k].v1[i])) + $signed(64'(prv[k].q[i]));
						end else begin
							x[i] = 64'($signed(prv[k].v1[i])) - $signed(64'(prv[k].q[i]));
						end
						c[i]           = clip32(x[i]);
						nxt[k].vout[i] = c[i][31:0];
					end
					nxt[k].sat = prv[k].sat | c[0][32] | c[1][32] | c[2][32];
				end
			end
		end
	endgenerate

	always_comb begin
		result.new_vel_x = pipe_s[NST].coll ? pipe_s[NST].vout[0] : pipe_s[NST].vin[0];
		result.new_vel_y = pipe_s[NST].coll ? pipe_s[NST].vout[1] : pipe_s[NST].vin[1];
		result.new_vel_z = pipe_s[NST].coll ? pipe_s[NST].vout[2] : pipe_s[NST].vin[2];
		result.collided  = pipe_s[NST].coll;
		result.sliding   = pipe_s[NST].coll && pipe_s[NST].slide;
		result.saturated = pipe_s[NST].coll && pipe_s[NST].sat;
	end

endmodule
